// ===== rtl/xdm_pkg.sv =====
`timescale 1ns / 1ps

package xdm_pkg;

  // Stream widths: fields packed from bit 0 upward, zero filled to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CMD_W       = 9;

  // Translate components are Q16 percent; 26 bits hold the CORDIC growth
  localparam int POS_W = 26;

  // Two-entry queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Vector is rescaled to length 100 when x*x + y*y exceeds this
  localparam logic [16:0] NORM_LIMIT = 17'd10000;
  localparam logic [14:0] PCT_FULL   = 15'd100;

  // 1/K for the CORDIC gain, Q30
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // Arctangent of 2^-i as a fraction of a turn, 32-bit
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_DEADZONE   = 2'd0,
    CFG_SCALE_FULL = 2'd1,
    CFG_SCALE_HALF = 2'd2,
    CFG_SCALE_SLOW = 2'd3
  } cfg_reg_e;

  // Speed button codes, also the remembered speed mode
  typedef enum logic [1:0] {
    SPD_NONE = 2'd0,
    SPD_FULL = 2'd1,
    SPD_HALF = 2'd2,
    SPD_SLOW = 2'd3
  } speed_sel_e;

  typedef struct packed {
    logic [6:0] deadzone;
    logic [8:0] scale_full;
    logic [8:0] scale_half;
    logic [8:0] scale_slow;
  } xdm_cfg_t;

  // Input beat, lowest field last
  typedef struct packed {
    logic [1:0]        speed_button;
    logic [15:0]       heading;
    logic signed [7:0] stick_rot;
    logic signed [7:0] stick_y;
    logic signed [7:0] stick_x;
  } xdm_in_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic signed [7:0] sr;
    logic [15:0]       m2;
    logic              need_norm;
    logic [8:0]        scale;
  } xdm_item_t;

  // Result beat, front left in the lowest bits
  typedef struct packed {
    logic [CMD_W-1:0] front_right_cmd;
    logic [CMD_W-1:0] back_right_cmd;
    logic [CMD_W-1:0] back_left_cmd;
    logic [CMD_W-1:0] front_left_cmd;
  } xdm_cmd_t;

endpackage

// ===== rtl/xdm_front.sv =====
`timescale 1ns / 1ps

module xdm_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  xdm_pkg::xdm_in_t      in_data_i,
  input  xdm_pkg::xdm_cfg_t     cfg_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output xdm_pkg::xdm_item_t    item_o,
  output logic [ANGLE_BITS-1:0] ang_o
);
  import xdm_pkg::*;

  speed_sel_e speed_mode_q, speed_mode_d;
  speed_sel_e btn;
  logic signed [7:0]  sx, sy, sr;
  logic signed [15:0] sq_x, sq_y;
  logic [16:0]        m2_w;
  logic [39:0]        hd_wide;
  logic [8:0]         scale;

  // Axis below the deadzone reads as zero; -128 has magnitude 128
  function automatic logic signed [7:0] dz(input logic signed [7:0] v,
                                           input logic [6:0] lim);
    logic [7:0] mag;
    mag = v[7] ? 8'(-v) : 8'(v);
    return (mag < {1'b0, lim}) ? 8'sd0 : v;
  endfunction

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Axis conditioning and squared length
  always_comb begin
    sx   = dz(in_data_i.stick_x, cfg_i.deadzone);
    sy   = dz(in_data_i.stick_y, cfg_i.deadzone);
    sr   = dz(in_data_i.stick_rot, cfg_i.deadzone);
    sq_x = sx * sx;
    sq_y = sy * sy;
    m2_w = 17'(sq_x) + 17'(sq_y);
  end

  // Speed button updates the mode before its scale is taken
  always_comb begin
    btn          = speed_sel_e'(in_data_i.speed_button);
    speed_mode_d = speed_mode_q;
    if (push_o && btn != SPD_NONE) begin
      speed_mode_d = btn;
    end
    case (speed_mode_d)
      SPD_FULL: scale = cfg_i.scale_full;
      SPD_SLOW: scale = cfg_i.scale_slow;
      default:  scale = cfg_i.scale_half;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_mode_q <= SPD_HALF;
    end else begin
      speed_mode_q <= speed_mode_d;
    end
  end

  // Heading widened or narrowed to the angle width
  assign hd_wide = {in_data_i.heading, 24'b0};
  assign ang_o   = hd_wide[39 -: ANGLE_BITS];

  always_comb begin
    item_o.sx        = sx;
    item_o.sy        = sy;
    item_o.sr        = sr;
    item_o.m2        = m2_w[15:0];
    item_o.need_norm = m2_w > NORM_LIMIT;
    item_o.scale     = scale;
  end

endmodule

// ===== rtl/xdm_queue.sv =====
`timescale 1ns / 1ps

module xdm_queue #(
  parameter int DW    = 16,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = count_q == CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/xdm_back.sv =====
`timescale 1ns / 1ps

module xdm_back #(
  parameter int ANGLE_BITS   = 16,
  parameter int ROTATE_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  xdm_pkg::xdm_item_t    q_item_i,
  input  logic [ANGLE_BITS-1:0] q_ang_i,
  output logic                  q_pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output xdm_pkg::xdm_cmd_t     m_data_o
);
  import xdm_pkg::*;

  localparam int ZW     = ANGLE_BITS + 1;
  localparam int PROD_W = 57;
  localparam int MIX_W  = 36;
  localparam logic [4:0] SQRT_LAST = 5'd23;
  localparam logic [4:0] DIV_LAST  = 5'd22;
  localparam logic [4:0] ROT_LAST  = 5'(ROTATE_STEPS - 1);
  localparam logic [32:0] ATAN_RND = 33'd1 << (31 - ANGLE_BITS);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQRT   = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_QUAD   = 8'b0000_1000,
    ST_CORDIC = 8'b0001_0000,
    ST_GAIN   = 8'b0010_0000,
    ST_MIX    = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  xdm_item_t             it_q, it_d;
  logic [ANGLE_BITS-1:0] ang_q, ang_d;
  logic signed [POS_W-1:0]  px_q, px_d, py_q, py_d;
  logic signed [ZW-1:0]     z_q, z_d;
  logic [47:0] sq_n_q, sq_n_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [23:0] root_q, root_d;
  logic [23:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [22:0] dq_x_q, dq_x_d, dq_y_q, dq_y_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [3:0][CMD_W-1:0]    cmd_q, cmd_d;
  logic [3:0][CMD_W-1:0]    out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  // Datapath temporaries
  logic [47:0] sq_try;
  logic [23:0] root_new;
  logic [7:0]  mag_x, mag_y;
  logic [14:0] ax, ay;
  logic [46:0] dvd_x, dvd_y;
  logic [24:0] trial_x, trial_y;
  logic        ge_x, ge_y;
  logic [1:0]  quad;
  logic signed [POS_W-1:0]  dx, dy, mul_a, rot_q16, mix_a, mix_b, mix_sum;
  logic [32:0]              t_full;
  logic signed [ZW-1:0]     t_ang;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [9:0]        scale_s;
  logic signed [MIX_W-1:0]  mix_prod, mix_rnd;
  logic [1:0]               k;

  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = xdm_cmd_t'(out_q);

  // Shared arithmetic
  always_comb begin
    // Root step: one result bit per cycle
    sq_try = sq_res_q + sq_bit_q;

    // Dividends for the rescale: |s| * 100 * 2^32 + r / 2
    mag_x    = it_q.sx[7] ? 8'(-it_q.sx) : 8'(it_q.sx);
    mag_y    = it_q.sy[7] ? 8'(-it_q.sy) : 8'(it_q.sy);
    ax       = 15'(mag_x) * PCT_FULL;
    ay       = 15'(mag_y) * PCT_FULL;
    root_new = sq_res_d[23:0];
    dvd_x    = {1'b0, ax[13:0], 9'b0, root_new[23:1]};
    dvd_y    = {1'b0, ay[13:0], 9'b0, root_new[23:1]};

    // Restoring divide step, both lanes share the divisor
    trial_x = {rem_x_q, dq_x_q[22]};
    trial_y = {rem_y_q, dq_y_q[22]};
    ge_x    = trial_x >= {1'b0, root_q};
    ge_y    = trial_y >= {1'b0, root_q};

    // CORDIC step
    quad   = ang_q[ANGLE_BITS-1 -: 2];
    dx     = py_q >>> cnt_q;
    dy     = px_q >>> cnt_q;
    t_full = {1'b0, ATAN_TURN32[cnt_q]} + ATAN_RND;
    t_ang  = $signed(t_full[32 -: ZW]);

    // Gain removal, one multiplier used twice
    mul_a   = cnt_q[0] ? py_q : px_q;
    prod_d  = PROD_W'(mul_a) * PROD_W'(GAIN_Q30);
    rnd_sum = prod_q + (PROD_W'(1) <<< 29);

    // Wheel mixing, one wheel per cycle
    k        = cnt_q[1:0];
    rot_q16  = {{2{it_q.sr[7]}}, it_q.sr, 16'b0};
    mix_a    = (k == 2'd0 || k == 2'd2) ? (px_q + py_q) : (px_q - py_q);
    mix_b    = (k == 2'd0 || k == 2'd3) ? rot_q16 : -rot_q16;
    mix_sum  = mix_a + mix_b;
    scale_s  = $signed({1'b0, it_q.scale});
    mix_prod = MIX_W'(mix_sum) * MIX_W'(scale_s);
    mix_rnd  = mix_prod + (MIX_W'(1) <<< 23);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    it_d        = it_q;
    ang_d       = ang_q;
    px_d        = px_q;
    py_d        = py_q;
    z_d         = z_q;
    sq_n_d      = sq_n_q;
    sq_res_d    = sq_res_q;
    sq_bit_d    = sq_bit_q;
    root_d      = root_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    dq_x_d      = dq_x_q;
    dq_y_d      = dq_y_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Root step result, used by the sqrt state and the divide setup
    if (sq_n_q >= sq_try) begin
      sq_n_d   = sq_n_q - sq_try;
      sq_res_d = (sq_res_q >> 1) + sq_bit_q;
    end else begin
      sq_res_d = sq_res_q >> 1;
    end
    sq_bit_d = sq_bit_q >> 2;

    case (state_q)
      ST_IDLE: begin
        sq_n_d   = sq_n_q;
        sq_res_d = sq_res_q;
        sq_bit_d = sq_bit_q;
        if (q_valid_i) begin
          it_d  = q_item_i;
          ang_d = q_ang_i;
          cnt_d = '0;
          px_d  = {{2{q_item_i.sx[7]}}, q_item_i.sx, 16'b0};
          py_d  = {{2{q_item_i.sy[7]}}, q_item_i.sy, 16'b0};
          if (q_item_i.need_norm) begin
            sq_n_d   = {q_item_i.m2, 32'b0};
            sq_res_d = '0;
            sq_bit_d = 48'd1 << 46;
            state_d  = ST_SQRT;
          end else begin
            state_d = ST_QUAD;
          end
        end
      end

      ST_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) begin
          root_d  = root_new;
          rem_x_d = dvd_x[46:23];
          rem_y_d = dvd_y[46:23];
          dq_x_d  = dvd_x[22:0];
          dq_y_d  = dvd_y[22:0];
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_x_d = ge_x ? 24'(trial_x - {1'b0, root_q}) : trial_x[23:0];
        rem_y_d = ge_y ? 24'(trial_y - {1'b0, root_q}) : trial_y[23:0];
        dq_x_d  = {dq_x_q[21:0], ge_x};
        dq_y_d  = {dq_y_q[21:0], ge_y};
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          // Quotients rounded half away from zero carry the axis sign
          px_d    = it_q.sx[7] ? -POS_W'(dq_x_d) : POS_W'(dq_x_d);
          py_d    = it_q.sy[7] ? -POS_W'(dq_y_d) : POS_W'(dq_y_d);
          cnt_d   = '0;
          state_d = ST_QUAD;
        end
      end

      ST_QUAD: begin
        // Whole quarter turns are exact
        case (quad)
          2'd1: begin
            px_d = -py_q;
            py_d = px_q;
          end
          2'd2: begin
            px_d = -px_q;
            py_d = -py_q;
          end
          2'd3: begin
            px_d = py_q;
            py_d = -px_q;
          end
          default: ;
        endcase
        z_d     = $signed({3'b0, ang_q[ANGLE_BITS-3:0]});
        cnt_d   = '0;
        state_d = ST_CORDIC;
      end

      ST_CORDIC: begin
        if (!z_q[ZW-1]) begin
          px_d = px_q - dx;
          py_d = py_q + dy;
          z_d  = z_q - t_ang;
        end else begin
          px_d = px_q + dx;
          py_d = py_q - dy;
          z_d  = z_q + t_ang;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ROT_LAST) begin
          cnt_d   = '0;
          state_d = ST_GAIN;
        end
      end

      ST_GAIN: begin
        // x multiplied, then x rounded while y multiplied, then y rounded
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd1) begin
          px_d = rnd_sum[55:30];
        end else if (cnt_q == 5'd2) begin
          py_d    = rnd_sum[55:30];
          cnt_d   = '0;
          state_d = ST_MIX;
        end
      end

      ST_MIX: begin
        cmd_d[k] = mix_rnd[32:24];
        cnt_d    = cnt_q + 5'd1;
        if (k == 2'd3) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || m_ready_i) begin
          out_d       = cmd_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    it_q     <= it_d;
    ang_q    <= ang_d;
    px_q     <= px_d;
    py_q     <= py_d;
    z_q      <= z_d;
    sq_n_q   <= sq_n_d;
    sq_res_q <= sq_res_d;
    sq_bit_q <= sq_bit_d;
    root_q   <= root_d;
    rem_x_q  <= rem_x_d;
    rem_y_q  <= rem_y_d;
    dq_x_q   <= dq_x_d;
    dq_y_q   <= dq_y_d;
    prod_q   <= prod_d;
    cmd_q    <= cmd_d;
    out_q    <= out_d;
  end

endmodule

// ===== rtl/field_centric_xdrive_mixer_core.sv =====
`timescale 1ns / 1ps

// Field-centric X-drive mixer. Each input beat is one control sample (strafe,
// forward and rotate stick in percent, a 16-bit binary heading and a speed
// button code); each yields one output beat of four 9-bit wheel commands,
// rounded integer percent, wrapped and not saturated. The front end applies
// the deadzone, updates the speed mode and picks the scale as a beat is
// taken, then hands the sample through a two-entry queue to the back end.
// The back end works on one sample at a time and rotates it with the
// one-step-per-cycle CORDIC rotator; a translate vector longer than 100
// first passes the bit-serial square root and the shared two-lane divider.
// The front end keeps taking beats while the queue has room, and a
// finished result waits in its own output register.

module field_centric_xdrive_mixer_core #(
  parameter int ANGLE_BITS   = 16,
  parameter int ROTATE_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: stick_x[7:0], stick_y[15:8], stick_rot[23:16], heading[39:24],
  //        speed_button[41:40], zero fill
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [xdm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tdata: front_left_cmd[8:0], back_left_cmd[17:9], back_right_cmd[26:18],
  //        front_right_cmd[35:27], zero fill
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [xdm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [8:0]                         cfg_data_i
);
  import xdm_pkg::*;

  localparam int QW = $bits(xdm_item_t) + ANGLE_BITS;

  xdm_cfg_t              cfg_q;
  xdm_in_t               in_data;
  xdm_item_t             f_item, b_item;
  logic [ANGLE_BITS-1:0] f_ang, b_ang;
  logic                  q_full, q_push, q_pop, q_valid;
  logic [QW-1:0]         q_rdata;
  xdm_cmd_t              cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone   <= 7'd3;
      cfg_q.scale_full <= 9'd256;
      cfg_q.scale_half <= 9'd128;
      cfg_q.scale_slow <= 9'd77;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEADZONE:   cfg_q.deadzone   <= cfg_data_i[6:0];
        CFG_SCALE_FULL: cfg_q.scale_full <= cfg_data_i;
        CFG_SCALE_HALF: cfg_q.scale_half <= cfg_data_i;
        CFG_SCALE_SLOW: cfg_q.scale_slow <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_data = xdm_in_t'(s_axis_tdata[$bits(xdm_in_t)-1:0]);

  xdm_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (in_data),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (f_item),
    .ang_o      (f_ang)
  );

  xdm_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_ang, f_item}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_item = xdm_item_t'(q_rdata[$bits(xdm_item_t)-1:0]);
  assign b_ang  = q_rdata[QW-1 -: ANGLE_BITS];

  xdm_back #(
    .ANGLE_BITS   (ANGLE_BITS),
    .ROTATE_STEPS (ROTATE_STEPS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (b_item),
    .q_ang_i   (b_ang),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (cmd)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - $bits(xdm_cmd_t)){1'b0}}, cmd};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import xdm_pkg::*;

  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int ROT_STEPS     = 16;

  // Arctangent of 2^-i in 32-bit turns, first ROT_STEPS entries
  localparam longint ATAN_T32 [ROT_STEPS] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
  };
  localparam longint INV_GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_Q30     = 64'sd1 <<< 29;
  localparam longint HALF_Q24     = 64'sd1 <<< 23;

  // Predicts the wheel commands of each accepted sample and matches result beats
  class wheel_cmd_tracker;
    xdm_cmd_t   cmds_due[$];
    int         fault_count;
    logic [6:0] deadzone;
    logic [8:0] scale_full;
    logic [8:0] scale_half;
    logic [8:0] scale_slow;
    speed_sel_e speed_mode;

    function new();
      deadzone    = 7'd3;
      scale_full  = 9'd256;
      scale_half  = 9'd128;
      scale_slow  = 9'd77;
      speed_mode  = SPD_HALF;
      fault_count = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [8:0] val);
      case (idx)
        CFG_DEADZONE:   deadzone   = val[6:0];
        CFG_SCALE_FULL: scale_full = val;
        CFG_SCALE_HALF: scale_half = val;
        CFG_SCALE_SLOW: scale_slow = val;
        default: ;
      endcase
    endfunction

    function longint clip_axis(logic signed [7:0] a);
      longint v;
      v = a;
      return ((v < 0 ? -v : v) < longint'(deadzone)) ? 0 : v;
    endfunction

    // Halves rounded away from zero; den is positive
    function longint div_round(longint num, longint den);
      longint mag, quo;
      mag = num < 0 ? -num : num;
      quo = (mag + den / 2) / den;
      return num < 0 ? -quo : quo;
    endfunction

    // Q16 wheel sum times Q8 scale, rounded half up to percent, wrapped to 9 bits
    function logic [CMD_W-1:0] pct_round(longint sum, longint sc);
      longint v;
      v = (sum * sc + HALF_Q24) >>> 24;
      return v[CMD_W-1:0];
    endfunction

    function void take_sample(xdm_in_t s);
      longint sx, sy, sr, m2, px, py, z, t, dx, dy, tmp, rot, sc;
      longint unsigned num, root, bitv;
      int quad;
      xdm_cmd_t want;
      sx = clip_axis(s.stick_x);
      sy = clip_axis(s.stick_y);
      sr = clip_axis(s.stick_rot);

      // speed button takes effect on this very sample
      if (s.speed_button != SPD_NONE) speed_mode = speed_sel_e'(s.speed_button);
      case (speed_mode)
        SPD_FULL: sc = scale_full;
        SPD_SLOW: sc = scale_slow;
        default:  sc = scale_half;
      endcase

      // limit translate vector to length 100 (Q16 percent)
      m2 = sx * sx + sy * sy;
      if (m2 > 10000) begin
        num  = m2;
        num  = num << 32;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (num >= root + bitv) begin
            num  = num - (root + bitv);
            root = (root >> 1) + bitv;
          end else begin
            root = root >> 1;
          end
          bitv = bitv >> 2;
        end
        px = div_round(sx * 100 * (64'sd1 <<< 32), longint'(root));
        py = div_round(sy * 100 * (64'sd1 <<< 32), longint'(root));
      end else begin
        px = sx * 65536;
        py = sy * 65536;
      end

      // whole quarter turns first, remainder by CORDIC
      quad = s.heading[15:14];
      for (int k = 0; k < quad; k++) begin
        tmp = px;
        px  = -py;
        py  = tmp;
      end
      z = s.heading[13:0];
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        t  = (ATAN_T32[i] + (64'sd1 <<< 15)) >>> 16;
        if (z >= 0) begin
          px = px - dx;
          py = py + dy;
          z  = z - t;
        end else begin
          px = px + dx;
          py = py - dy;
          z  = z + t;
        end
      end
      px = (px * INV_GAIN_Q30 + HALF_Q30) >>> 30;
      py = (py * INV_GAIN_Q30 + HALF_Q30) >>> 30;

      rot = sr * 65536;
      want.front_left_cmd  = pct_round(px + py + rot, sc);
      want.back_left_cmd   = pct_round(px - py - rot, sc);
      want.back_right_cmd  = pct_round(px + py - rot, sc);
      want.front_right_cmd = pct_round(px - py + rot, sc);
      cmds_due.push_back(want);
    endfunction

    function void cmp_field(string name, logic [CMD_W-1:0] want, logic [CMD_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
        fault_count++;
      end
    endfunction

    function void match_cmds(logic [OUT_TDATA_W-1:0] tdata);
      xdm_cmd_t got, want;
      got = tdata[$bits(xdm_cmd_t)-1:0];
      if (cmds_due.size() == 0) begin
        $error("wheel command beat with no sample pending: %h", tdata);
        fault_count++;
        return;
      end
      want = cmds_due.pop_front();
      cmp_field("front_left_cmd",  want.front_left_cmd,  got.front_left_cmd);
      cmp_field("back_left_cmd",   want.back_left_cmd,   got.back_left_cmd);
      cmp_field("back_right_cmd",  want.back_right_cmd,  got.back_right_cmd);
      cmp_field("front_right_cmd", want.front_right_cmd, got.front_right_cmd);
    endfunction
  endclass

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we   = 1'b0;
  cfg_reg_e               cfg_idx  = CFG_DEADZONE;
  logic [8:0]             cfg_data = '0;
  bit                     idle_on  = 1'b1;
  bit                     hold_rx  = 1'b0;

  wheel_cmd_tracker tracker = new();

  always #5 clk_i = ~clk_i;

  field_centric_xdrive_mixer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  // Result beats sampled mid-cycle, where they hold steady up to the edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) tracker.match_cmds(m_axis_tdata);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : sink_ready
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Ends the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk_i);
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic xdm_in_t pack_sample(int x, int y, int r, int hd, speed_sel_e b);
    xdm_in_t s;
    s.stick_x      = 8'(x);
    s.stick_y      = 8'(y);
    s.stick_rot    = 8'(r);
    s.heading      = 16'(hd);
    s.speed_button = b;
    return s;
  endfunction

  // Mostly in range, some near the deadzone, some any 8-bit code
  function automatic logic signed [7:0] rand_axis();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(0, 8) - 4);
      default: return 8'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  function automatic xdm_in_t rand_sample();
    xdm_in_t s;
    s.stick_x   = rand_axis();
    s.stick_y   = rand_axis();
    s.stick_rot = rand_axis();
    s.heading   = 16'($urandom_range(0, 65535));
    // now and then sit right on a quadrant boundary
    if ($urandom_range(0, 7) == 0)
      s.heading = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
    s.speed_button = $urandom_range(0, 1) ? 2'($urandom_range(1, 3)) : SPD_NONE;
    return s;
  endfunction

  // One sample beat; acceptance seen mid-cycle, handshake completes at the edge
  task automatic send_sample(xdm_in_t s);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(s);
    do begin
      @(negedge clk_i);
      taken = s_tvalid && s_axis_tready;
      if (taken) tracker.take_sample(s);
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Stop offering and wait for every pending result beat
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.cmds_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [8:0] dz, logic [8:0] full, logic [8:0] half,
                           logic [8:0] slow);
    logic [8:0] vals [4];
    vals = '{dz, full, half, slow};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    xdm_in_t opening[$];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples at reset settings
    opening.push_back(pack_sample(   0,    0,    0, 'h0000, SPD_NONE));
    opening.push_back(pack_sample( 100,    0,    0, 'h0000, SPD_FULL));
    opening.push_back(pack_sample(   0,  100,    0, 'h4000, SPD_NONE));
    opening.push_back(pack_sample( 100,  100,    0, 'h8000, SPD_NONE));
    opening.push_back(pack_sample(-100, -100,    0, 'hC000, SPD_HALF));
    opening.push_back(pack_sample( 127,  127,  127, 'hFFFF, SPD_FULL));
    opening.push_back(pack_sample(-128, -128, -128, 'h2000, SPD_SLOW));
    opening.push_back(pack_sample(-128,    0,    0, 'h0001, SPD_NONE));
    opening.push_back(pack_sample(   2,   -2,    2, 'h1000, SPD_NONE));
    opening.push_back(pack_sample(   3,   -3,   -3, 'h3FFF, SPD_NONE));
    opening.push_back(pack_sample(   0,    0,  100, 'h4001, SPD_FULL));
    opening.push_back(pack_sample(   0,    0, -100, 'h7FFF, SPD_NONE));
    opening.push_back(pack_sample(  60,   80,    0, 'h6000, SPD_NONE));
    opening.push_back(pack_sample(  61,   80,    0, 'hA000, SPD_NONE));
    opening.push_back(pack_sample(-100,  100,   50, 'hE000, SPD_SLOW));
    opening.push_back(pack_sample( 127, -128, -100, 'h5555, SPD_HALF));
    opening.push_back(pack_sample(  -1,    1,   -2, 'hAAAA, SPD_NONE));
    opening.push_back(pack_sample( 100, -100,  100, 'hFFFF, SPD_FULL));
    foreach (opening[i]) send_sample(opening[i]);

    // Random phases, each under its own register settings
    for (int ph = 1; ph <= 6; ph++) begin
      drain();
      case (ph)
        1: load_regs(9'd0, 9'd256, 9'd128, 9'd77);
        2: load_regs(9'd100, 9'd511, 9'd0, 9'd256);
        3: load_regs(9'h1FF, 9'd0, 9'd511, 9'd1);
        4: load_regs(9'($urandom_range(0, 15)), 9'($urandom_range(0, 511)),
                     9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        5: load_regs(9'($urandom_range(0, 15)), 9'($urandom_range(0, 256)),
                     9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)));
        default: load_regs(9'd3, 9'd256, 9'd128, 9'd77);
      endcase
      idle_on = (ph != 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while samples keep coming
        if (ph == 4 && n == 20) hold_rx = 1'b1;
        send_sample(rand_sample());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.fault_count == 0 && tracker.cmds_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
